[rtl/ecsm_pkg.sv]
package ecsm_pkg;

    localparam int FIELD_BITS_DEF  = 16;
    localparam int SCALAR_BITS_DEF = 16;

    localparam logic [0:0] REG_CURVE_A = 1'b0;
    localparam logic [0:0] REG_PRIME   = 1'b1;

    localparam int CURVE_A_RESET = 2;
    localparam int PRIME_RESET   = 97;

    // Opcodes of the field arithmetic unit.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_INV = 2'd1;
    localparam logic [1:0] OP_RED = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_cmd;

endpackage

[rtl/ecsm_alu.sv]
module ecsm_alu #(
    parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ecsm_pkg::t_alu_cmd      i_cmd,
    input  logic [FIELD_BITS-1:0]   i_a,
    input  logic [FIELD_BITS-1:0]   i_b,
    input  logic [FIELD_BITS-1:0]   i_p,
    output logic                    o_done,
    output logic [FIELD_BITS-1:0]   o_res
);
    // One bit per cycle: modular multiply by shift-and-add, modular reduction by
    // restoring shift-subtract, and inverse by the binary extended Euclidean method.
    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(2 * W + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_INV  = 2'd2;
    localparam logic [1:0] S_RED  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W:0]    r_acc, n_acc;
    logic [W-1:0]  r_sh, n_sh;
    logic [W:0]    r_u, n_u, r_v, n_v, r_x1, n_x1, r_x2, n_x2;
    logic          r_done, n_done;
    logic [W-1:0]  r_res, n_res;

    logic [W+1:0] dbl, dblp, addb;
    logic [W:0]   h1, h2;
    logic [W+1:0] tadd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_sh    = r_sh;
        n_u     = r_u;
        n_v     = r_v;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_done  = 1'b0;
        n_res   = r_res;
        dbl     = '0;
        dblp    = '0;
        addb    = '0;
        h1      = '0;
        h2      = '0;
        tadd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_acc = '0;
                    n_cnt = '0;
                    case (i_cmd.op)
                        ecsm_pkg::OP_MUL: begin
                            n_sh    = i_b;
                            n_u     = {1'b0, i_a};
                            n_state = S_MUL;
                        end
                        ecsm_pkg::OP_INV: begin
                            n_u     = {1'b0, i_a};
                            n_v     = {1'b0, i_p};
                            n_x1    = {{W{1'b0}}, 1'b1};
                            n_x2    = '0;
                            n_state = S_INV;
                        end
                        default: begin
                            n_sh    = i_a;
                            n_state = S_RED;
                        end
                    endcase
                end
            end
            S_MUL: begin
                // Horner over multiplier bits, MSB first; accumulator stays below p.
                dbl  = {r_acc, 1'b0};
                dblp = (dbl >= {1'b0, i_p}) ? dbl - {1'b0, i_p} : dbl;
                addb = dblp + (r_sh[W-1] ? {1'b0, r_u} : '0);
                if (addb >= {1'b0, i_p}) addb = addb - {1'b0, i_p};
                n_acc = addb[W:0];
                n_sh  = {r_sh[W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_res   = addb[W-1:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RED: begin
                dbl = {r_acc, r_sh[W-1]};
                if (dbl >= {1'b0, i_p}) dbl = dbl - {1'b0, i_p};
                n_acc = dbl[W:0];
                n_sh  = {r_sh[W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_res   = dbl[W-1:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                // Binary inverse; a*x1 = u, a*x2 = v (mod p) invariants, p odd.
                if (r_u == '0 || r_v == '0) begin
                    // gcd found or zero operand: inverse exists only when a 1 remains.
                    n_res   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_u == {{W{1'b0}}, 1'b1}) begin
                    n_res   = r_x1[W-1:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_v == {{W{1'b0}}, 1'b1}) begin
                    n_res   = r_x2[W-1:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_u[0]) begin
                    n_u  = r_u >> 1;
                    tadd = r_x1[0] ? {1'b0, r_x1} + {2'b0, i_p} : {1'b0, r_x1};
                    n_x1 = tadd[W+1:1];
                end else if (!r_v[0]) begin
                    n_v  = r_v >> 1;
                    tadd = r_x2[0] ? {1'b0, r_x2} + {2'b0, i_p} : {1'b0, r_x2};
                    n_x2 = tadd[W+1:1];
                end else if (r_u >= r_v) begin
                    n_u  = r_u - r_v;
                    h1   = r_x1 - r_x2;
                    n_x1 = (r_x1 >= r_x2) ? h1 : h1 + {1'b0, i_p};
                end else begin
                    n_v  = r_v - r_u;
                    h2   = r_x2 - r_x1;
                    n_x2 = (r_x2 >= r_x1) ? h2 : h2 + {1'b0, i_p};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_u   <= n_u;
        r_v   <= n_v;
        r_x1  <= n_x1;
        r_x2  <= n_x2;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

[rtl/ec_scalar_multiply_mod_p.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// cfg      | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data (curve_a, prime)
// input    | i_valid/o_ready        | i_scalar_k, i_base_x, i_base_y
// result   | o_valid/i_ready        | o_result_x, o_result_y, o_at_infinity
//
// One transaction is processed at a time. Each scalar bit costs a point double
// (four multiplies and one inverse) and possibly an add (three multiplies and one
// inverse) in the shared field unit.
// Reset is synchronous and active low and restores curve_a = 2, prime = 97.
// A result waits in the output register while the next transaction is taken.
module ec_scalar_multiply_mod_p #(
    parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
    parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic [FIELD_BITS-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SCALAR_BITS-1:0] i_scalar_k,
    input  logic [FIELD_BITS-1:0]  i_base_x,
    input  logic [FIELD_BITS-1:0]  i_base_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [FIELD_BITS-1:0]  o_result_x,
    output logic [FIELD_BITS-1:0]  o_result_y,
    output logic                   o_at_infinity
);
    localparam int W  = FIELD_BITS;
    localparam int SW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

    // Sequencer states. Each point step is a list of field operations.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RA    = 5'd1;  // reduce a
    localparam logic [4:0] S_RX    = 5'd2;  // reduce base x
    localparam logic [4:0] S_RY    = 5'd3;  // reduce base y
    localparam logic [4:0] S_BIT   = 5'd4;  // start of one scalar bit: double
    localparam logic [4:0] S_D1    = 5'd5;  // x*x
    localparam logic [4:0] S_D2    = 5'd6;  // inv(2y)
    localparam logic [4:0] S_D3    = 5'd7;  // (3xx+a)*inv
    localparam logic [4:0] S_ADD   = 5'd8;  // decide add
    localparam logic [4:0] S_A1    = 5'd9;  // inv(bx-x)
    localparam logic [4:0] S_A2    = 5'd10; // (by-y)*inv
    localparam logic [4:0] S_L1    = 5'd11; // lam*lam
    localparam logic [4:0] S_L2    = 5'd12; // lam*(x - xr)
    localparam logic [4:0] S_NEXT  = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;

    logic [4:0]             r_state, n_state;
    logic                   r_ret_add, n_ret_add; // which step the lambda tail serves
    logic [W-1:0]           r_a, r_p;
    logic [W-1:0]           r_ca, n_ca, r_bx, n_bx, r_by, n_by;
    logic [W-1:0]           r_x, n_x, r_y, n_y, r_t, n_t, r_lam, n_lam, r_xr, n_xr;
    logic                   r_inf, n_inf;
    logic [SCALAR_BITS-1:0] r_k, n_k;
    logic [SW-1:0]          r_bit, n_bit;
    logic                   r_busy, n_busy;
    logic                   r_ov, n_ov;
    logic [W-1:0]           r_ox, n_ox, r_oy, n_oy;
    logic                   r_oi, n_oi;

    ecsm_pkg::t_alu_cmd     alu_cmd;
    logic [W-1:0]           alu_a, alu_b, alu_res;
    logic                   alu_done;

    // Field helpers on values below p.
    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, u} - {1'b0, v};
        if (u < v) s = s + {1'b0, p};
        return s[W-1:0];
    endfunction

    ecsm_alu #(.FIELD_BITS(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (alu_cmd),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_p    (r_p),
        .o_done (alu_done),
        .o_res  (alu_res)
    );

    assign o_cfg_ready = !r_busy;
    assign o_ready     = !r_busy;

    logic p_ok;
    assign p_ok = (r_p >= W'(3));

    always_comb begin
        n_state   = r_state;
        n_ret_add = r_ret_add;
        n_ca = r_ca; n_bx = r_bx; n_by = r_by;
        n_x = r_x; n_y = r_y; n_t = r_t; n_lam = r_lam; n_xr = r_xr;
        n_inf = r_inf; n_k = r_k; n_bit = r_bit; n_busy = r_busy;
        n_ov = r_ov; n_ox = r_ox; n_oy = r_oy; n_oi = r_oi;
        alu_cmd.start = 1'b0;
        alu_cmd.op    = ecsm_pkg::OP_MUL;
        alu_a = '0;
        alu_b = '0;
        if (o_valid && i_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_busy = 1'b1;
                    n_k    = i_scalar_k;
                    n_bx   = i_base_x;
                    n_by   = i_base_y;
                    n_inf  = 1'b1;
                    n_x    = '0;
                    n_y    = '0;
                    n_bit  = SW'(SCALAR_BITS - 1);
                    if (p_ok) begin
                        n_state       = S_RA;
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ecsm_pkg::OP_RED;
                        alu_a         = r_a;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RA: if (alu_done) begin
                n_ca = alu_res;
                alu_cmd.start = 1'b1; alu_cmd.op = ecsm_pkg::OP_RED; alu_a = r_bx;
                n_state = S_RX;
            end
            S_RX: if (alu_done) begin
                n_bx = alu_res;
                alu_cmd.start = 1'b1; alu_cmd.op = ecsm_pkg::OP_RED; alu_a = r_by;
                n_state = S_RY;
            end
            S_RY: if (alu_done) begin
                n_by = alu_res;
                n_state = S_BIT;
            end
            S_BIT: begin
                // Doubling: infinity stays infinity; y = 0 gives infinity.
                if (r_inf) begin
                    n_state = S_ADD;
                end else if (r_y == '0) begin
                    n_inf = 1'b1; n_x = '0; n_y = '0;
                    n_state = S_ADD;
                end else begin
                    alu_cmd.start = 1'b1; alu_a = r_x; alu_b = r_x;
                    n_state = S_D1;
                end
            end
            S_D1: if (alu_done) begin
                n_t = f_add(f_add(f_add(alu_res, alu_res, r_p), alu_res, r_p), r_ca, r_p);
                alu_cmd.start = 1'b1; alu_cmd.op = ecsm_pkg::OP_INV;
                alu_a = f_add(r_y, r_y, r_p);
                n_state = S_D2;
            end
            S_D2: if (alu_done) begin
                alu_cmd.start = 1'b1; alu_a = r_t; alu_b = alu_res;
                n_ret_add = 1'b0;
                n_state = S_D3;
            end
            S_D3, S_A2: if (alu_done) begin
                n_lam = alu_res;
                alu_cmd.start = 1'b1; alu_a = alu_res; alu_b = alu_res;
                n_state = S_L1;
            end
            S_L1: if (alu_done) begin
                // Second operand is x for doubling, base x for addition.
                n_xr = f_sub(f_sub(alu_res, r_x, r_p), r_ret_add ? r_bx : r_x, r_p);
                alu_cmd.start = 1'b1; alu_a = r_lam;
                alu_b = f_sub(r_x, f_sub(f_sub(alu_res, r_x, r_p),
                              r_ret_add ? r_bx : r_x, r_p), r_p);
                n_state = S_L2;
            end
            S_L2: if (alu_done) begin
                n_y = f_sub(alu_res, r_y, r_p);
                n_x = r_xr;
                n_state = r_ret_add ? S_NEXT : S_ADD;
            end
            S_ADD: begin
                if (!r_k[r_bit]) begin
                    n_state = S_NEXT;
                end else if (r_inf) begin
                    n_inf = 1'b0; n_x = r_bx; n_y = r_by;
                    n_state = S_NEXT;
                end else if (r_x == r_bx) begin
                    if (r_y != r_by || r_y == '0) begin
                        n_inf = 1'b1; n_x = '0; n_y = '0;
                        n_state = S_NEXT;
                    end else begin
                        // Same point: a doubling that then skips the add.
                        n_ret_add = 1'b1;
                        alu_cmd.start = 1'b1; alu_a = r_x; alu_b = r_x;
                        n_state = S_D1;
                    end
                end else begin
                    alu_cmd.start = 1'b1; alu_cmd.op = ecsm_pkg::OP_INV;
                    alu_a = f_sub(r_bx, r_x, r_p);
                    n_state = S_A1;
                end
            end
            S_A1: if (alu_done) begin
                alu_cmd.start = 1'b1; alu_a = f_sub(r_by, r_y, r_p); alu_b = alu_res;
                n_ret_add = 1'b1;
                n_state = S_A2;
            end
            S_NEXT: begin
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_bit = r_bit - 1'b1;
                    n_state = S_BIT;
                end
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1;
                    n_ox = r_inf ? '0 : r_x;
                    n_oy = r_inf ? '0 : r_y;
                    n_oi = r_inf;
                    n_busy = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // The doubling entered from the add decision returns through S_D2 with
        // r_ret_add set; keep that flag when S_D2 issues the multiply.
        if (r_state == S_D2 && alu_done && r_ret_add) n_ret_add = 1'b1;
    end

    // In the doubling path S_D2 would clear the flag; restore it for equal points.
    logic r_eqdbl, n_eqdbl;
    always_comb begin
        n_eqdbl = r_eqdbl;
        if (r_state == S_ADD) n_eqdbl = 1'b0;
        if (r_state == S_ADD && r_k[r_bit] && !r_inf && r_x == r_bx && r_y == r_by
            && r_y != '0) n_eqdbl = 1'b1;
        if (r_state == S_BIT) n_eqdbl = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            r_a     <= W'(ecsm_pkg::CURVE_A_RESET);
            r_p     <= W'(ecsm_pkg::PRIME_RESET);
            r_eqdbl <= 1'b0;
            r_ret_add <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_ov    <= n_ov;
            r_eqdbl <= n_eqdbl;
            r_ret_add <= (r_state == S_D2 && alu_done) ? r_eqdbl : n_ret_add;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ecsm_pkg::REG_CURVE_A) r_a <= i_cfg_data;
                else r_p <= i_cfg_data;
            end
        end
        r_ca <= n_ca; r_bx <= n_bx; r_by <= n_by;
        r_x <= n_x; r_y <= n_y; r_t <= n_t; r_lam <= n_lam; r_xr <= n_xr;
        r_inf <= n_inf; r_k <= n_k; r_bit <= n_bit;
        r_ox <= n_ox; r_oy <= n_oy; r_oi <= n_oi;
    end

    assign o_valid       = r_ov;
    assign o_result_x    = r_ox;
    assign o_result_y    = r_oy;
    assign o_at_infinity = r_oi;

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_infinity |-> o_result_x == '0 && o_result_y == '0)
        else $error("infinity result with nonzero coordinates");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready)
        else $error("input accepted while a transaction is in progress");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_x) && $stable(o_result_y))
        else $error("pending result changed");
endmodule

[tb/ec_scalar_multiply_mod_p_checker.sv]
// Watches the three channels of the scalar multiplier, predicts every result
// from its own copy of the curve registers and compares what comes out.
module ec_scalar_multiply_mod_p_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [15:0] i_scalar_k,
    input  logic [15:0] i_base_x,
    input  logic [15:0] i_base_y,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_result_x,
    input  logic [15:0] i_result_y,
    input  logic        i_at_infinity,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        longint x;
        longint y;
        bit     inf;
    } ec_point_t;

    typedef struct {
        bit [15:0] x;
        bit [15:0] y;
        bit        inf;
    } product_t;

    longint    coef_a;
    longint    modulus;
    product_t  product_q[$];

    function automatic longint mod_sub(longint u, longint v, longint p);
        return (u + p - v) % p;
    endfunction

    // Extended Euclid; a denominator with no inverse maps to zero.
    function automatic longint mod_inverse(longint v, longint p);
        longint r0, r1, t0, t1, q, nr, nt;
        r0 = p;
        r1 = v % p;
        t0 = 0;
        t1 = 1;
        if (r1 == 0) return 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            nt = t0 - q * t1;
            r0 = r1; r1 = nr;
            t0 = t1; t1 = nt;
        end
        if (r0 != 1) return 0;
        if (t0 < 0) t0 += p;
        return t0 % p;
    endfunction

    function automatic ec_point_t point_sum(ec_point_t s, ec_point_t t, longint a, longint p);
        ec_point_t r;
        longint lam, xr;
        r.inf = 1; r.x = 0; r.y = 0;
        if (s.inf) return t;
        if (t.inf) return s;
        if (s.x == t.x) begin
            if (s.y != t.y || s.y == 0) return r;
            lam = (3 * ((s.x * s.x) % p) + a) % p;
            lam = (lam * mod_inverse((2 * s.y) % p, p)) % p;
        end else begin
            lam = (mod_sub(t.y, s.y, p) * mod_inverse(mod_sub(t.x, s.x, p), p)) % p;
        end
        xr = mod_sub(mod_sub((lam * lam) % p, s.x, p), t.x, p);
        r.y = mod_sub((lam * mod_sub(s.x, xr, p)) % p, s.y, p);
        r.x = xr;
        r.inf = 0;
        return r;
    endfunction

    function automatic product_t scalar_product(bit [15:0] k, bit [15:0] bx, bit [15:0] by);
        ec_point_t base, acc;
        longint a;
        product_t res;
        acc.inf = 1; acc.x = 0; acc.y = 0;
        if (modulus >= 3) begin
            a = coef_a % modulus;
            base.x = bx % modulus;
            base.y = by % modulus;
            base.inf = 0;
            for (int i = 15; i >= 0; i--) begin
                acc = point_sum(acc, acc, a, modulus);
                if (k[i]) acc = point_sum(acc, base, a, modulus);
            end
        end
        res.inf = acc.inf;
        res.x = acc.inf ? 16'd0 : acc.x[15:0];
        res.y = acc.inf ? 16'd0 : acc.y[15:0];
        return res;
    endfunction

    assign o_pending = product_q.size();

    always @(posedge i_clk) begin
        product_t want;
        if (!i_rst_n) begin
            coef_a  <= ecsm_pkg::CURVE_A_RESET;
            modulus <= ecsm_pkg::PRIME_RESET;
            product_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == ecsm_pkg::REG_CURVE_A) coef_a <= i_cfg_data;
                else if (i_cfg_index == ecsm_pkg::REG_PRIME) modulus <= i_cfg_data;
            end
            if (i_valid && i_ready_in)
                product_q.push_back(scalar_product(i_scalar_k, i_base_x, i_base_y));
            if (i_out_valid && i_out_ready) begin
                if (product_q.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d inf=%0d",
                           i_result_x, i_result_y, i_at_infinity);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = product_q.pop_front();
                    if (want.x !== i_result_x || want.y !== i_result_y ||
                        want.inf !== i_at_infinity) begin
                        if (want.x !== i_result_x)
                            $error("result_x expected %0d actual %0d", want.x, i_result_x);
                        if (want.y !== i_result_y)
                            $error("result_y expected %0d actual %0d", want.y, i_result_y);
                        if (want.inf !== i_at_infinity)
                            $error("at_infinity expected %0d actual %0d",
                                   want.inf, i_at_infinity);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/ec_scalar_multiply_mod_p_test.sv]
// Stimulus and verdict for the scalar multiplier. The checker beside the DUT
// does all prediction and comparison; this module only drives transactions,
// reprograms the curve between phases and decides pass or fail at the end.
module ec_scalar_multiply_mod_p_test;
    // This limit leaves several times the slowest correct run for roughly 170 transactions.
    localparam int CYCLE_LIMIT = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_scalar_k;
    logic [15:0] i_base_x;
    logic [15:0] i_base_y;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_result_x;
    logic [15:0] o_result_y;
    logic        o_at_infinity;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int cycle_count;

    ec_scalar_multiply_mod_p DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_scalar_k(i_scalar_k), .i_base_x(i_base_x), .i_base_y(i_base_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_x(o_result_x), .o_result_y(o_result_y),
        .o_at_infinity(o_at_infinity)
    );

    ec_scalar_multiply_mod_p_checker product_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_scalar_k(i_scalar_k), .i_base_x(i_base_x), .i_base_y(i_base_y),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_result_x(o_result_x), .i_result_y(o_result_y),
        .i_at_infinity(o_at_infinity),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver drops ready at random, at a rate set per phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // A run that hangs is cut off here with a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one transaction. Valid is only lowered when the sender decides
    // to idle, so back-to-back transactions never lower and raise it in the
    // same time step.
    task automatic send_point(input logic [15:0] k, input logic [15:0] x,
                              input logic [15:0] y);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_scalar_k <= k;
        i_base_x   <= x;
        i_base_y   <= y;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Writes both curve registers once the block has drained every result.
    // It first waits so that the checker has queued the last transaction.
    task automatic program_curve(input logic [15:0] a, input logic [15:0] p);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ecsm_pkg::REG_CURVE_A;
        i_cfg_data  <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= ecsm_pkg::REG_PRIME;
        i_cfg_data  <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random transactions: small scalars often, so that the accumulator
    // lands on the point at infinity and on point-plus-negative cases.
    task automatic random_points(input int count);
        logic [15:0] k;
        for (int n = 0; n < count; n++) begin
            k = ($urandom_range(2) == 0) ? 16'($urandom_range(20)) : 16'($urandom);
            send_point(k, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ecsm_pkg::REG_CURVE_A;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_scalar_k  = '0;
        i_base_x    = '0;
        i_base_y    = '0;
        i_ready     = 1'b1;
        send_idle   = 0;
        recv_idle   = 0;
        cycle_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset curve: zero scalar, unit scalar, full
        // scalar with coordinates that need reduction, and points with y = 0
        // (directly and after reduction) whose doubling is infinity.
        send_point(16'd0, 16'd3, 16'd6);
        send_point(16'd1, 16'd3, 16'd6);
        send_point(16'd2, 16'd3, 16'd6);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(16'd2, 16'd5, 16'd0);
        send_point(16'd3, 16'd7, 16'd97);
        send_point(16'h8000, 16'd1, 16'd96);

        // Largest coefficient on the largest 16-bit prime.
        program_curve(16'hFFFF, 16'd65521);
        send_point(16'hFFFF, 16'd12345, 16'd54321);
        send_point(16'h5555, 16'hFFFF, 16'h0000);
        send_point(16'd1, 16'd65521, 16'd65522);

        // Moduli below three give infinity for everything.
        program_curve(16'd0, 16'd2);
        send_point(16'd5, 16'd1, 16'd1);
        program_curve(16'd7, 16'd0);
        send_point(16'hFFFF, 16'd1, 16'd1);
        program_curve(16'd7, 16'd1);
        send_point(16'd3, 16'd0, 16'd0);

        // Composite moduli, where some denominators have no inverse.
        program_curve(16'd0, 16'd15);
        send_point(16'd7, 16'd3, 16'd5);
        send_point(16'hFFFF, 16'd6, 16'd10);
        program_curve(16'd1, 16'hFFFF);
        send_point(16'hAAAA, 16'd300, 16'd7);
        send_point(16'd4, 16'd5, 16'd65534);

        // Phase one: slow sender is rare, receiver stalls most of the time.
        program_curve(16'd1, 16'd5);
        send_idle = 8;
        recv_idle = 67;
        random_points(50);

        // Phase two: the other way round.
        program_curve(16'($urandom), 16'd65521);
        send_idle = 67;
        recv_idle = 8;
        random_points(50);

        // Phase three: no idling on either side.
        program_curve(16'd0, 16'd97);
        send_idle = 0;
        recv_idle = 0;
        random_points(50);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
